[hdl/ismf_pkg.sv]
// shared types and constants for the in-place 3x3 smoothing filter
// no dependencies; imported by every module of the block but ismf_ram

package ismf_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 1024;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int CNT_W      = LINE_AW + 1;

   // field widths
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int ROW_W    = 10;
   localparam int COLUMN_W = 10;
   localparam int IWIDTH_W = 11;
   localparam int BAND_W   = 10;
   localparam int SUM_W    = 12;

   // fill count saturates one past a full line
   localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(LINE_DEPTH + 1);
   localparam int               MIN_WIDTH = 3;

   // rounding and divide by ten through a reciprocal
   localparam logic [SUM_W-1:0]  ROUND_BIAS  = SUM_W'(5);
   localparam logic [SUM_W-1:0]  RECIP_TEN   = SUM_W'(3277);
   localparam int                RECIP_SHIFT = 15;
   localparam logic [CHAN_W-1:0] CHAN_MAX    = '1;

   // register port
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BAND_FIRST_ROW = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_BAND_ROW_COUNT = 2'd2;

   localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RESET    = IWIDTH_W'(640);
   localparam logic [BAND_W-1:0]   BAND_FIRST_ROW_RESET = BAND_W'(32);
   localparam logic [BAND_W-1:0]   BAND_ROW_COUNT_RESET = BAND_W'(64);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sum_type;

   // per-word control decided at the input side
   typedef struct packed {
      logic               drop;
      logic               has_result;
      logic               smooth;
      logic [LINE_AW-1:0] col;
      logic [ROW_W-1:0]   out_row;
      logic [LINE_AW-1:0] out_col;
   } item_ctl_type;

endpackage

[hdl/ismf_ram.sv]
// generic single-write, single-read synchronous ram, read-first, registered read
// no dependencies

module ismf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ismf_position.sv]
// raster position, fill and drain tracking for incoming words
// depends on ismf_pkg

module ismf_position
   import ismf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IWIDTH_W-1:0] image_width,
   input  logic [BAND_W-1:0]   band_first_row,
   input  logic [BAND_W-1:0]   band_row_count,
   input  logic                advance,
   input  logic                flush,
   input  logic                frame_start,
   output item_ctl_type        item_ctl
);

   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [LINE_AW-1:0] in_col_ff, in_col_in;
   logic [CNT_W-1:0]   filled_ff, filled_in;
   logic [CNT_W-1:0]   drain_ff, drain_in;

   logic [CNT_W-1:0]   width, width_plus1, col_inc, filled_base;
   logic [LINE_AW-1:0] col_base, col_cur;
   logic [ROW_W-1:0]   row_base, row_cur, res_row;
   logic [LINE_AW-1:0] res_col;
   logic [BAND_W:0]    band_end;
   logic               restart, smooth_row;

   function automatic logic [CNT_W-1:0] clamp_width(input logic [IWIDTH_W-1:0] iw);
      logic [CNT_W-1:0] w;
      if (int'(iw) < MIN_WIDTH) begin
         w = CNT_W'(MIN_WIDTH);
      end else if (int'(iw) > LINE_DEPTH) begin
         w = CNT_W'(LINE_DEPTH);
      end else begin
         w = CNT_W'(iw);
      end
      return w;
   endfunction

   always_comb begin
      width       = clamp_width(image_width);
      width_plus1 = width + CNT_W'(1);
      restart     = !flush && frame_start;
      row_base    = restart ? '0 : in_row_ff;
      col_base    = restart ? '0 : in_col_ff;
      filled_base = restart ? '0 : filled_ff;

      // a column left beyond a narrowed width wraps first
      if (CNT_W'(col_base) >= width) begin
         col_cur = '0;
         row_cur = row_base + ROW_W'(1);
      end else begin
         col_cur = col_base;
         row_cur = row_base;
      end

      // due result is one row and one pixel back
      if (col_cur != '0) begin
         res_row = row_cur - ROW_W'(1);
         res_col = col_cur - LINE_AW'(1);
      end else begin
         res_row = row_cur - ROW_W'(2);
         res_col = LINE_AW'(width - CNT_W'(1));
      end

      band_end   = (BAND_W+1)'(band_first_row) + (BAND_W+1)'(band_row_count);
      smooth_row = (res_row != '0) && (res_row >= band_first_row) &&
                   ((BAND_W+1)'(res_row) < band_end);

      item_ctl.drop       = flush && (drain_ff >= width_plus1);
      item_ctl.has_result = filled_base >= width_plus1;
      item_ctl.smooth     = !flush && (col_cur >= LINE_AW'(2)) && smooth_row;
      item_ctl.col        = col_cur;
      item_ctl.out_row    = res_row;
      item_ctl.out_col    = res_col;

      col_inc = CNT_W'(col_cur) + CNT_W'(1);
      if (col_inc >= width) begin
         in_col_in = '0;
         in_row_in = row_cur + ROW_W'(1);
      end else begin
         in_col_in = col_cur + LINE_AW'(1);
         in_row_in = row_cur;
      end
      filled_in = (filled_base >= FILL_MAX) ? filled_base : filled_base + CNT_W'(1);
      drain_in  = flush ? drain_ff + CNT_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
         filled_ff <= '0;
         drain_ff  <= '0;
      end else if (advance && !item_ctl.drop) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
         filled_ff <= filled_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

[hdl/ismf_window.sv]
// 3x3 window registers and partial neighbor sum, one column a word
// depends on ismf_pkg

module ismf_window
   import ismf_pkg::*;
(
   input  logic      clock,
   input  logic      advance,
   input  pixel_type above_pix,
   input  pixel_type upper_right,
   input  pixel_type pix,
   output sum_type   part_sum,
   output pixel_type pass_pix
);

   pixel_type center_ff, up_ff, up_left_ff, down_left_ff, down_ff, pass_ff;
   sum_type   part_sum_ff, part_sum_in;

   // everything but the left neighbor, with the rounding bias folded in
   function automatic logic [SUM_W-1:0] chan_sum(
      input logic [CHAN_W-1:0] ul, input logic [CHAN_W-1:0] u,
      input logic [CHAN_W-1:0] ur, input logic [CHAN_W-1:0] ctr,
      input logic [CHAN_W-1:0] rt, input logic [CHAN_W-1:0] dl,
      input logic [CHAN_W-1:0] d,  input logic [CHAN_W-1:0] dr);
      logic [SUM_W-1:0] upper, lower;
      upper = SUM_W'(ul) + SUM_W'(u) + SUM_W'(ur) + SUM_W'(rt);
      lower = SUM_W'(dl) + SUM_W'(d) + SUM_W'(dr) + ROUND_BIAS;
      return upper + lower + SUM_W'(ctr) + SUM_W'(ctr);
   endfunction

   always_comb begin
      part_sum_in.red   = chan_sum(up_left_ff.red, up_ff.red, upper_right.red,
                                   center_ff.red, above_pix.red, down_left_ff.red,
                                   down_ff.red, pix.red);
      part_sum_in.green = chan_sum(up_left_ff.green, up_ff.green, upper_right.green,
                                   center_ff.green, above_pix.green, down_left_ff.green,
                                   down_ff.green, pix.green);
      part_sum_in.blue  = chan_sum(up_left_ff.blue, up_ff.blue, upper_right.blue,
                                   center_ff.blue, above_pix.blue, down_left_ff.blue,
                                   down_ff.blue, pix.blue);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         center_ff    <= above_pix;
         up_ff        <= upper_right;
         up_left_ff   <= up_ff;
         down_left_ff <= down_ff;
         down_ff      <= pix;
         part_sum_ff  <= part_sum_in;
         pass_ff      <= center_ff;
      end
   end

   assign part_sum = part_sum_ff;
   assign pass_pix = pass_ff;

endmodule

[hdl/ismf_output.sv]
// final divide by ten with the left result fed back, and the result register
// depends on ismf_pkg

module ismf_output
   import ismf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                smooth,
   input  sum_type             part_sum,
   input  pixel_type           pass_pix,
   input  logic [ROW_W-1:0]    row,
   input  logic [LINE_AW-1:0]  col,
   input  logic                rsp_stall,
   output logic                out_free,
   output pixel_type           result,
   output logic                rsp_valid,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue,
   output logic [ROW_W-1:0]    rsp_out_row,
   output logic [COLUMN_W-1:0] rsp_out_column
);

   logic                valid_ff, valid_in;
   pixel_type           pix_ff;
   pixel_type           left_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COLUMN_W-1:0] column_ff;

   function automatic logic [CHAN_W-1:0] div10_sat(input logic [SUM_W-1:0] s);
      logic [2*SUM_W-1:0] prod, quot;
      prod = (2*SUM_W)'(s) * (2*SUM_W)'(RECIP_TEN);
      quot = prod >> RECIP_SHIFT;
      if (quot > (2*SUM_W)'(CHAN_MAX)) begin
         return CHAN_MAX;
      end
      return quot[CHAN_W-1:0];
   endfunction

   always_comb begin
      if (smooth) begin
         result.red   = div10_sat(part_sum.red + SUM_W'(left_ff.red));
         result.green = div10_sat(part_sum.green + SUM_W'(left_ff.green));
         result.blue  = div10_sat(part_sum.blue + SUM_W'(left_ff.blue));
      end else begin
         result = pass_pix;
      end
      out_free = !valid_ff || !rsp_stall;
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            left_ff <= result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff    <= result;
         row_ff    <= row;
         column_ff <= COLUMN_W'(col);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_red    = pix_ff.red;
   assign rsp_out_green  = pix_ff.green;
   assign rsp_out_blue   = pix_ff.blue;
   assign rsp_out_row    = row_ff;
   assign rsp_out_column = column_ff;

endmodule

[hdl/inplace_3x3_smoothing_filter.sv]
// top level of the in-place 3x3 weighted smoothing filter
// depends on ismf_pkg, ismf_ram, ismf_position, ismf_window, ismf_output

// In-place 3x3 smoothing on a raster stream of 8-bit RGB pixels. Inside the
// programmed band of rows, each inner pixel becomes (2*center + eight
// neighbors)/10 rounded to nearest, where the upper three and left neighbors
// are already-filtered values. Other pixels pass through. One word is taken
// per clock cycle sustained while the output is not stalled; a word passes
// through line memory read, window sum, divide and result register, and the
// rate is set by the left-neighbor feedback in the final stage, one add and
// one reciprocal multiply per cycle. Results lag the input stream by one row
// plus one pixel: send flush words at frame end to drain them. The line
// memories have no reset and need no clearing pass; a result register holds
// the output word, and a stalled result stalls the input as soon as both
// pipeline stages behind it hold words, in the same cycle when words come
// back to back.

module inplace_3x3_smoothing_filter
   import ismf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input words
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_flush,
   input  logic                req_frame_start,
   input  logic [CHAN_W-1:0]   req_in_red,
   input  logic [CHAN_W-1:0]   req_in_green,
   input  logic [CHAN_W-1:0]   req_in_blue,
   // result words
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue,
   output logic [ROW_W-1:0]    rsp_out_row,
   output logic [COLUMN_W-1:0] rsp_out_column,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   // configuration registers
   logic [IWIDTH_W-1:0] image_width_ff;
   logic [BAND_W-1:0]   band_first_row_ff;
   logic [BAND_W-1:0]   band_row_count_ff;
   logic                csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   // input side
   item_ctl_type item_ctl;
   pixel_type    pix_in;
   logic         accept, s1_load;

   // stage 1: memory read in flight
   logic         s1_valid_ff, s1_valid_in;
   item_ctl_type s1_ctl_ff;
   pixel_type    s1_pix_ff;
   logic         fwd_hit_ff, fwd_hit_in;
   pixel_type    fwd_pix_ff, fwd_pix_in;
   pixel_type    above_rd, upper_rd, upper_right;
   logic         s1_move, s1_free;

   // stage 2: window sum held
   logic         s2_valid_ff, s2_valid_in;
   item_ctl_type s2_ctl_ff;
   sum_type      part_sum;
   pixel_type    pass_pix;
   logic         s2_move, s2_free;

   // output stage
   logic         out_free, out_load;
   pixel_type    result;

   // ---------------------------------------------------------------------
   // register port: writes complete in the access phase, pready tied high
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= IMAGE_WIDTH_RESET;
         band_first_row_ff <= BAND_FIRST_ROW_RESET;
         band_row_count_ff <= BAND_ROW_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:    image_width_ff    <= pwdata[IWIDTH_W-1:0];
            REG_BAND_FIRST_ROW: band_first_row_ff <= pwdata[BAND_W-1:0];
            REG_BAND_ROW_COUNT: band_row_count_ff <= pwdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:    prdata = CSR_DW'(image_width_ff);
         REG_BAND_FIRST_ROW: prdata = CSR_DW'(band_first_row_ff);
         REG_BAND_ROW_COUNT: prdata = CSR_DW'(band_row_count_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // pipeline flow: each stage moves when the one ahead frees up; words
   // without a due result leave stage 2 without touching the output
   // ---------------------------------------------------------------------
   always_comb begin
      s2_move   = s2_valid_ff && (!s2_ctl_ff.has_result || out_free);
      s2_free   = !s2_valid_ff || s2_move;
      s1_move   = s1_valid_ff && s2_free;
      s1_free   = !s1_valid_ff || s1_move;
      req_stall = !s1_free;
      accept    = req_valid && !req_stall;
      // a flush past the drained lag is taken and does nothing
      s1_load   = accept && !item_ctl.drop;
      out_load  = s2_move && s2_ctl_ff.has_result;

      s1_valid_in = s1_load || (s1_valid_ff && !s1_move);
      s2_valid_in = s1_move || (s2_valid_ff && !s2_move);
   end

   // flush words carry a zero pixel into the line store
   assign pix_in = req_flush ? '0 : {req_in_red, req_in_green, req_in_blue};

   ismf_position u_position (
      .clock          (clock),
      .reset          (reset),
      .image_width    (image_width_ff),
      .band_first_row (band_first_row_ff),
      .band_row_count (band_row_count_ff),
      .advance        (accept),
      .flush          (req_flush),
      .frame_start    (req_frame_start),
      .item_ctl       (item_ctl)
   );

   // input line: read the row above at this column, then overwrite it
   // with the new pixel (read-first at the same address)
   ismf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_DEPTH)
   ) u_input_line (
      .clock   (clock),
      .wr_en   (s1_load),
      .wr_addr (item_ctl.col),
      .wr_data (pix_in),
      .rd_en   (s1_load),
      .rd_addr (item_ctl.col),
      .rd_data (above_rd)
   );

   // output line: filtered row above; read at the word's column, written
   // at the result column when a result leaves stage 2
   ismf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_DEPTH)
   ) u_output_line (
      .clock   (clock),
      .wr_en   (out_load),
      .wr_addr (s2_ctl_ff.out_col),
      .wr_data (result),
      .rd_en   (s1_load),
      .rd_addr (item_ctl.col),
      .rd_data (upper_rd)
   );

   // forwarding: on narrow lines a result write can land on the entry a
   // younger word has already read, so catch it while that word waits
   always_comb begin
      fwd_hit_in = fwd_hit_ff;
      fwd_pix_in = fwd_pix_ff;
      if (s1_load) begin
         fwd_hit_in = out_load && (s2_ctl_ff.out_col == item_ctl.col);
         fwd_pix_in = result;
      end else if (s1_valid_ff && out_load && (s2_ctl_ff.out_col == s1_ctl_ff.col)) begin
         fwd_hit_in = 1'b1;
         fwd_pix_in = result;
      end
   end

   assign upper_right = fwd_hit_ff ? fwd_pix_ff : upper_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_pix_ff <= fwd_pix_in;
      if (s1_load) begin
         s1_ctl_ff <= item_ctl;
         s1_pix_ff <= pix_in;
      end
      if (s1_move) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   ismf_window u_window (
      .clock       (clock),
      .advance     (s1_move),
      .above_pix   (above_rd),
      .upper_right (upper_right),
      .pix         (s1_pix_ff),
      .part_sum    (part_sum),
      .pass_pix    (pass_pix)
   );

   ismf_output u_output (
      .clock          (clock),
      .reset          (reset),
      .load           (out_load),
      .smooth         (s2_ctl_ff.smooth),
      .part_sum       (part_sum),
      .pass_pix       (pass_pix),
      .row            (s2_ctl_ff.out_row),
      .col            (s2_ctl_ff.out_col),
      .rsp_stall      (rsp_stall),
      .out_free       (out_free),
      .result         (result),
      .rsp_valid      (rsp_valid),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_column (rsp_out_column)
   );

endmodule

[hdl/ismf_checker.sv]
// port-level checks for the in-place 3x3 smoothing filter, bound to the top level
// depends on ismf_pkg and inplace_3x3_smoothing_filter

module ismf_checker
   import ismf_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [CHAN_W-1:0]   rsp_out_red,
   input logic [CHAN_W-1:0]   rsp_out_green,
   input logic [CHAN_W-1:0]   rsp_out_blue,
   input logic [ROW_W-1:0]    rsp_out_row,
   input logic [COLUMN_W-1:0] rsp_out_column
);

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up when a result is waiting on a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // a stalled result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_red) && $stable(rsp_out_green) &&
                                    $stable(rsp_out_blue) && $stable(rsp_out_row) &&
                                    $stable(rsp_out_column)))
      else $error("result changed while stalled");

endmodule

bind inplace_3x3_smoothing_filter ismf_checker u_ismf_checker (.*);
